// File: rtl/particle_pool_integrator_macros.svh
// Assertion helpers used by the file that checks the pool logic.
`ifndef PARTICLE_POOL_INTEGRATOR_MACROS_SVH
`define PARTICLE_POOL_INTEGRATOR_MACROS_SVH

`define PPI_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PPI_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ppi_pkg.sv
package ppi_pkg;

  localparam int POOL_SIZE_DEF = 64;

  localparam logic [1:0] CMD_EMIT    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_READOUT = 2'd2;

  localparam logic REG_GRAVITY = 1'b0;

  localparam logic signed [31:0] GRAVITY_RESET = -32'sd642253;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] spawn_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic [23:0]        spawn_color;
    logic [15:0]        spawn_size;
    logic [23:0]        life_span;
    logic [15:0]        step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        out_size;
    logic [23:0]        out_color;
    logic [7:0]         out_alpha;
    logic               last_record;
    logic               none_alive;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        color;
    logic [15:0]        init_size;
    logic [23:0]        age;
    logic [23:0]        life;
  } rec_t;

endpackage

// File: rtl/ppi_mem.sv
module ppi_mem #(
  parameter int DEPTH = ppi_pkg::POOL_SIZE_DEF,
  parameter int AW    = $clog2(ppi_pkg::POOL_SIZE_DEF)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ppi_pkg::rec_t   wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output ppi_pkg::rec_t   rdata
);

  ppi_pkg::rec_t mem [DEPTH];
  ppi_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ppi_div.sv
module ppi_div #(
  parameter int NW = 32,
  parameter int DW = 24,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quo
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_r, lo_r[QW-1]};
  assign take  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = DW'(num >> QW);
      lo_nxt  = num[QW-1:0];
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt = take ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      lo_nxt  = {lo_r[QW-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = lo_r;

endmodule

// File: rtl/particle_pool_integrator.sv
// A readout word is presented for one cycle with out_strobe and must be taken then: the block
// never waits for its receiver. An emit writes its record into the ring slot without leaving
// idle. A tick walks every slot: it skips a dead slot, reads and age-checks a particle that
// dies at this tick, and takes one that lives on through read, age and gravity, velocity
// products and write-back, after a setup step for the gravity product. A readout walks the
// slots the same way; for each live particle it reads the record, loads the dividers, runs
// the sixteen steps of the divider that scales the size and presents the word. An empty pool
// is answered with a single word, without leaving idle. The state sits in one single-port-read,
// single-port-write memory with registered read data.
`include "particle_pool_integrator_macros.svh"

module particle_pool_integrator #(
  parameter int POOL_SIZE = ppi_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ppi_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output ppi_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SW = $clog2(POOL_SIZE);
  localparam logic [SW-1:0] LAST = SW'(POOL_SIZE - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TPREP = 3'd1;
  localparam logic [2:0] ST_TSCAN = 3'd2;
  localparam logic [2:0] ST_TAGE  = 3'd3;
  localparam logic [2:0] ST_TMUL  = 3'd4;
  localparam logic [2:0] ST_TPOS  = 3'd5;
  localparam logic [2:0] ST_RSCAN = 3'd6;
  localparam logic [2:0] ST_RDIV  = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [32:0] scale_dt(input logic signed [31:0] v,
                                                  input logic [15:0] dt);
    logic signed [48:0] p;
    p = 49'(v) * 49'($signed({1'b0, dt}));
    return $signed(p[48:16]);
  endfunction

  logic [2:0]             state_r, state_nxt;
  logic [SW-1:0]          slot_r, slot_nxt;
  logic [SW-1:0]          ring_r;
  logic [POOL_SIZE-1:0]   alive_r;
  logic signed [31:0]     gravity_r;
  logic [15:0]            dt_r;
  logic signed [32:0]     gdt_r;
  logic signed [32:0]     sx_r, sy_r, sz_r;
  ppi_pkg::rec_t          rec_r;
  logic                   life_zero_r;
  logic                   out_strobe_r;
  ppi_pkg::out_word_t     out_word_r, out_word_nxt;

  logic                   accept;
  logic                   mem_we, mem_re;
  logic [SW-1:0]          mem_waddr;
  ppi_pkg::rec_t          mem_wdata, rdata, rec_new, rec_aged;
  logic [24:0]            age_sum;
  logic [23:0]            age_n, age_c;
  logic [24:0]            two_l;
  logic [31:0]            alpha_d;
  logic [31:0]            alpha_num;
  logic [40:0]            size_num;
  logic                   busy_a, busy_s;
  logic [7:0]             quo_a;
  logic [15:0]            quo_s;
  logic [POOL_SIZE-1:0]   above;
  logic                   slot_last;
  logic                   rdiv_go;
  logic                   rdiv_first_r;
  logic                   rdiv_done;
  logic                   empty_rd;

  assign accept    = start && !busy;
  assign busy      = state_r != ST_IDLE;
  assign slot_last = slot_r == LAST;
  assign empty_rd  = accept && in_word.command == ppi_pkg::CMD_READOUT && alive_r == '0;
  assign rdiv_go   = state_r == ST_RDIV && rdiv_first_r;
  assign rdiv_done = state_r == ST_RDIV && !rdiv_first_r && !busy_a && !busy_s;

  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      above[i] = SW'(i) > slot_r;
    end
  end

  assign age_sum = {1'b0, rdata.age} + 25'(dt_r);
  assign age_n   = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
  assign age_c   = (rdata.age > rdata.life) ? rdata.life : rdata.age;
  assign two_l   = {rdata.life, 1'b0};
  assign alpha_d = {8'd0, rdata.life - age_c};
  assign alpha_num = (alpha_d << 8) - alpha_d;
  assign size_num  = 41'(rdata.init_size) * 41'(two_l - 25'(age_c));

  ppi_div #(.NW(32), .DW(24), .QW(8)) u_div_alpha (
    .clk(clk), .rst_n(rst_n), .start(rdiv_go), .num(alpha_num), .den(rdata.life),
    .busy(busy_a), .quo(quo_a)
  );

  ppi_div #(.NW(41), .DW(25), .QW(16)) u_div_size (
    .clk(clk), .rst_n(rst_n), .start(rdiv_go), .num(size_num), .den(two_l),
    .busy(busy_s), .quo(quo_s)
  );

  always_comb begin
    rec_new       = rec_r;
    rec_new.pos_x = sat32(34'(rec_r.pos_x) + 34'(sx_r));
    rec_new.pos_y = sat32(34'(rec_r.pos_y) + 34'(sy_r));
    rec_new.pos_z = sat32(34'(rec_r.pos_z) + 34'(sz_r));
  end

  always_comb begin
    rec_aged       = rdata;
    rec_aged.age   = age_n;
    rec_aged.vel_y = sat32(34'(rdata.vel_y) + 34'(gdt_r));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = rec_new;
    if (accept && in_word.command == ppi_pkg::CMD_EMIT) begin
      mem_we    = 1'b1;
      mem_waddr = ring_r;
      mem_wdata.pos_x     = in_word.spawn_x;
      mem_wdata.pos_y     = in_word.spawn_y;
      mem_wdata.pos_z     = in_word.spawn_z;
      mem_wdata.vel_x     = in_word.speed_x;
      mem_wdata.vel_y     = in_word.speed_y;
      mem_wdata.vel_z     = in_word.speed_z;
      mem_wdata.color     = in_word.spawn_color;
      mem_wdata.init_size = in_word.spawn_size;
      mem_wdata.age       = '0;
      mem_wdata.life      = in_word.life_span;
    end else if (state_r == ST_TPOS) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_r == ST_TSCAN || (state_r == ST_RSCAN)) && alive_r[slot_r];

  ppi_mem #(.DEPTH(POOL_SIZE), .AW(SW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(slot_r), .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        slot_nxt = '0;
        if (accept && in_word.command == ppi_pkg::CMD_TICK) begin
          state_nxt = ST_TPREP;
        end else if (accept && in_word.command == ppi_pkg::CMD_READOUT && alive_r != '0) begin
          state_nxt = ST_RSCAN;
        end
      end
      ST_TPREP: state_nxt = ST_TSCAN;
      ST_TSCAN: begin
        if (alive_r[slot_r]) begin
          state_nxt = ST_TAGE;
        end else if (slot_last) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_TAGE: begin
        if (age_n >= rdata.life) begin
          state_nxt = slot_last ? ST_IDLE : ST_TSCAN;
          slot_nxt  = slot_r + 1'b1;
        end else begin
          state_nxt = ST_TMUL;
        end
      end
      ST_TMUL: state_nxt = ST_TPOS;
      ST_TPOS: begin
        state_nxt = slot_last ? ST_IDLE : ST_TSCAN;
        slot_nxt  = slot_r + 1'b1;
      end
      ST_RSCAN: begin
        if (alive_r[slot_r]) begin
          state_nxt = ST_RDIV;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_RDIV: begin
        if (rdiv_done) begin
          state_nxt = ((alive_r & above) == '0) ? ST_IDLE : ST_RSCAN;
          slot_nxt  = slot_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_word_nxt = out_word_r;
    if (empty_rd) begin
      out_word_nxt             = '0;
      out_word_nxt.last_record = 1'b1;
      out_word_nxt.none_alive  = 1'b1;
    end else if (rdiv_done) begin
      out_word_nxt.out_x       = rec_r.pos_x;
      out_word_nxt.out_y       = rec_r.pos_y;
      out_word_nxt.out_z       = rec_r.pos_z;
      out_word_nxt.out_size    = life_zero_r ? (rec_r.init_size >> 1) : quo_s;
      out_word_nxt.out_color   = rec_r.color;
      out_word_nxt.out_alpha   = life_zero_r ? 8'd0 : quo_a;
      out_word_nxt.last_record = (alive_r & above) == '0;
      out_word_nxt.none_alive  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      ring_r       <= '0;
      alive_r      <= '0;
      gravity_r    <= ppi_pkg::GRAVITY_RESET;
      out_strobe_r <= 1'b0;
      rdiv_first_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      out_strobe_r <= empty_rd || rdiv_done;
      rdiv_first_r <= state_r == ST_RSCAN && alive_r[slot_r];
      if (psel && penable && pwrite && paddr[2] == ppi_pkg::REG_GRAVITY) begin
        gravity_r <= $signed(pwdata);
      end
      if (accept && in_word.command == ppi_pkg::CMD_EMIT) begin
        alive_r[ring_r] <= 1'b1;
        ring_r          <= (ring_r == LAST) ? '0 : ring_r + 1'b1;
      end
      if (state_r == ST_TAGE && age_n >= rdata.life) begin
        alive_r[slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt_r <= in_word.step_time;
    end
    if (state_r == ST_TPREP) begin
      gdt_r <= scale_dt(gravity_r, dt_r);
    end
    if (state_r == ST_TAGE) begin
      rec_r <= rec_aged;
    end
    if (state_r == ST_TMUL) begin
      sx_r <= scale_dt(rec_r.vel_x, dt_r);
      sy_r <= scale_dt(rec_r.vel_y, dt_r);
      sz_r <= scale_dt(rec_r.vel_z, dt_r);
    end
    if (rdiv_go) begin
      rec_r       <= rdata;
      life_zero_r <= rdata.life == '0;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign prdata     = (paddr[2] == ppi_pkg::REG_GRAVITY) ? gravity_r : 32'd0;
  assign pready     = 1'b1;

  `PPI_NEXT(a_tick_busy, accept && in_word.command == ppi_pkg::CMD_TICK, busy, "tick idle")
  `PPI_CHECK(a_empty_last, out_strobe && out_word.none_alive |-> out_word.last_record, "empty")
  `PPI_CHECK(a_last_idle, out_strobe && out_word.last_record |-> !busy, "busy after last word")
  `PPI_CHECK(a_mid_busy, out_strobe && !out_word.last_record |-> busy, "readout ended early")

endmodule

// File: verif/testbench.sv
module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SLOTS = ppi_pkg::POOL_SIZE_DEF;
  localparam logic [2:0] ADDR_GRAVITY = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ppi_pkg::in_word_t in_word = '0;
  logic out_strobe;
  ppi_pkg::out_word_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  particle_pool_integrator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [31:0] pos_x [SLOTS];
  logic signed [31:0] pos_y [SLOTS];
  logic signed [31:0] pos_z [SLOTS];
  logic signed [31:0] vel_x [SLOTS];
  logic signed [31:0] vel_y [SLOTS];
  logic signed [31:0] vel_z [SLOTS];
  logic [23:0] color [SLOTS];
  logic [15:0] init_size [SLOTS];
  logic [23:0] age [SLOTS];
  logic [23:0] life [SLOTS];
  logic alive [SLOTS];
  int unsigned ring = 0;
  logic signed [31:0] gravity = ppi_pkg::GRAVITY_RESET;

  ppi_pkg::out_word_t expected_records [$];
  int mismatches = 0;
  int idle_pct = 0;

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic longint times_dt(logic signed [31:0] v, logic [15:0] dt);
    longint p;
    p = longint'(v) * longint'(dt);
    return p >>> 16;
  endfunction

  task automatic advance_pool(ppi_pkg::in_word_t w);
    ppi_pkg::out_word_t r;
    longint unsigned lf, ag, sz;
    int n;
    n = 0;
    case (w.command)
      ppi_pkg::CMD_EMIT: begin
        pos_x[ring] = w.spawn_x;
        pos_y[ring] = w.spawn_y;
        pos_z[ring] = w.spawn_z;
        vel_x[ring] = w.speed_x;
        vel_y[ring] = w.speed_y;
        vel_z[ring] = w.speed_z;
        color[ring] = w.spawn_color;
        init_size[ring] = w.spawn_size;
        age[ring] = '0;
        life[ring] = w.life_span;
        alive[ring] = 1'b1;
        ring = (ring + 1) % SLOTS;
      end
      ppi_pkg::CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!alive[i]) continue;
          ag = age[i] + w.step_time;
          if (ag > 64'hffffff) ag = 64'hffffff;
          age[i] = ag[23:0];
          if (ag >= life[i]) begin
            alive[i] = 1'b0;
            continue;
          end
          vel_y[i] = clamp32(longint'(vel_y[i]) + times_dt(gravity, w.step_time));
          pos_x[i] = clamp32(longint'(pos_x[i]) + times_dt(vel_x[i], w.step_time));
          pos_y[i] = clamp32(longint'(pos_y[i]) + times_dt(vel_y[i], w.step_time));
          pos_z[i] = clamp32(longint'(pos_z[i]) + times_dt(vel_z[i], w.step_time));
        end
      end
      ppi_pkg::CMD_READOUT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!alive[i]) continue;
          r = '0;
          lf = life[i];
          ag = age[i];
          if (lf == 0) begin
            r.out_size = init_size[i] >> 1;
            r.out_alpha = '0;
          end else begin
            if (ag > lf) ag = lf;
            sz = (longint'(init_size[i]) * (2 * lf - ag)) / (2 * lf);
            r.out_size = sz[15:0];
            sz = (255 * (lf - ag)) / lf;
            r.out_alpha = sz[7:0];
          end
          r.out_x = pos_x[i];
          r.out_y = pos_y[i];
          r.out_z = pos_z[i];
          r.out_color = color[i];
          expected_records.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.none_alive = 1'b1;
          r.last_record = 1'b1;
          expected_records.push_back(r);
        end else begin
          expected_records[$].last_record = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        if (out_word !== expected_records[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected x=%h y=%h z=%h size=%h color=%h alpha=%h last=%b none=%b",
              expected_records[0].out_x, expected_records[0].out_y,
              expected_records[0].out_z, expected_records[0].out_size,
              expected_records[0].out_color, expected_records[0].out_alpha,
              expected_records[0].last_record, expected_records[0].none_alive);
            $display("          got      x=%h y=%h z=%h size=%h color=%h alpha=%h last=%b none=%b",
              out_word.out_x, out_word.out_y, out_word.out_z, out_word.out_size,
              out_word.out_color, out_word.out_alpha, out_word.last_record,
              out_word.none_alive);
          end
        end
        void'(expected_records.pop_front());
      end
    end
  end

  task automatic send_word(ppi_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    advance_pool(w);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain_pool;
    while (expected_records.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gravity(logic signed [31:0] value);
    drain_pool();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_GRAVITY;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    gravity = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic ppi_pkg::in_word_t emit_word(logic signed [31:0] px, logic signed [31:0] vx,
                                                  logic [23:0] col, logic [15:0] sz,
                                                  logic [23:0] lf);
    ppi_pkg::in_word_t w;
    w = '0;
    w.command = ppi_pkg::CMD_EMIT;
    w.spawn_x = px;
    w.spawn_y = px;
    w.spawn_z = px;
    w.speed_x = vx;
    w.speed_y = vx;
    w.speed_z = vx;
    w.spawn_color = col;
    w.spawn_size = sz;
    w.life_span = lf;
    return w;
  endfunction

  function automatic ppi_pkg::in_word_t control_word(logic [1:0] cmd, logic [15:0] dt);
    ppi_pkg::in_word_t w;
    w = '0;
    w.command = cmd;
    w.step_time = dt;
    return w;
  endfunction

  task automatic test_directed;
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    send_word(emit_word(32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 16'hffff, 24'hffffff));
    send_word(emit_word(32'sh80000000, 32'sh80000000, 24'h000000, 16'h0000, 24'hffffff));
    send_word(emit_word(32'sh00010000, -32'sh00020000, 24'h123456, 16'h8000, 24'd1));
    send_word(emit_word(32'sd0, 32'sd0, 24'hff00ff, 16'h7fff, 24'd70000));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    send_word(control_word(ppi_pkg::CMD_TICK, 16'd0));
    send_word(control_word(CMD_UNUSED, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    send_word(control_word(ppi_pkg::CMD_TICK, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    send_word(control_word(ppi_pkg::CMD_TICK, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    send_word(control_word(ppi_pkg::CMD_TICK, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
  endtask

  task automatic test_gravity;
    write_gravity(32'sh7fffffff);
    send_word(emit_word(32'sd0, 32'sd0, 24'h00ff00, 16'h1234, 24'd500000));
    send_word(control_word(ppi_pkg::CMD_TICK, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    write_gravity(32'sh80000000);
    send_word(control_word(ppi_pkg::CMD_TICK, 16'hffff));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    write_gravity(32'sd0);
    send_word(control_word(ppi_pkg::CMD_TICK, 16'd1000));
    send_word(control_word(ppi_pkg::CMD_READOUT, 16'd0));
    write_gravity(ppi_pkg::GRAVITY_RESET);
  endtask

  task automatic test_random(int count);
    ppi_pkg::in_word_t w;
    logic [287:0] bits;
    int pick;
    for (int k = 0; k < count; k++) begin
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
      w = bits[$bits(ppi_pkg::in_word_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 55) begin
        w.command = ppi_pkg::CMD_EMIT;
        if ($urandom_range(3) == 0) w.life_span = 24'($urandom_range(1, 20000));
        else if (w.life_span == 0) w.life_span = 24'd1;
      end else if (pick < 77) begin
        w.command = ppi_pkg::CMD_TICK;
        if ($urandom_range(3) != 0) w.step_time = 16'($urandom_range(0, 3000));
      end else if (pick < 95) begin
        w.command = ppi_pkg::CMD_READOUT;
      end else begin
        w.command = CMD_UNUSED;
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_pct = 28;
    test_directed();
    test_gravity();
    test_random(70);
    write_gravity($urandom);
    idle_pct = 52;
    test_random(70);
    write_gravity(32'sh00080000);
    idle_pct = 0;
    test_random(70);
    drain_pool();
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ppi_pkg.sv
rtl/ppi_mem.sv
rtl/ppi_div.sv
rtl/particle_pool_integrator.sv
verif/testbench.sv
